### rtl/asp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attribute screen pixel package
// Shared types, codes and constants of the attribute screen pixel generator.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int unsigned DISPLAY_DEPTH   = 6144;
    localparam int unsigned ATTRIBUTE_DEPTH = 768;
    localparam int unsigned DISP_AW         = $clog2(DISPLAY_DEPTH);
    localparam int unsigned ATTR_AW         = $clog2(ATTRIBUTE_DEPTH);

    localparam int unsigned CONTENT_TOP        = 32;
    localparam int unsigned CONTENT_BOTTOM_END = 32 + 192;
    localparam int unsigned CONTENT_LEFT       = 32 * 2;
    localparam int unsigned CONTENT_RIGHT_END  = (32 + 256) * 2;

    localparam int unsigned MID_DEPTH_DEF = 4;
    localparam int unsigned OUT_DEPTH_DEF = 4;

    localparam logic [1:0] FUNC_BEAM    = 2'd0;
    localparam logic [1:0] FUNC_DISP_WR = 2'd1;
    localparam logic [1:0] FUNC_ATTR_WR = 2'd2;

    localparam logic [7:0] ATTR_INK_MASK = 8'h07;
    localparam logic [7:0] ATTR_BRIGHT   = 8'h40;
    localparam logic [7:0] ATTR_FLASH    = 8'h80;
    localparam logic [7:0] BRIGHT_STEP   = 8'd8;

    localparam int unsigned CFG_DW = 9;
    localparam int unsigned CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_BORDER_COLOR  = 3'd0,
        CFG_CLIP_LEFT     = 3'd1,
        CFG_CLIP_RIGHT    = 3'd2,
        CFG_CLIP_TOP      = 3'd3,
        CFG_CLIP_BOTTOM   = 3'd4,
        CFG_INK_BASE      = 3'd5,
        CFG_PAPER_BASE    = 3'd6,
        CFG_BORDER_BASE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] border_color;
        logic [8:0] clip_left;
        logic [8:0] clip_right;
        logic [7:0] clip_top;
        logic [7:0] clip_bottom;
        logic [7:0] ink_base;
        logic [7:0] paper_base;
        logic [7:0] border_base;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        border_color:  3'd0,
        clip_left:     9'd0,
        clip_right:    9'd511,
        clip_top:      8'd0,
        clip_bottom:   8'd191,
        ink_base:      8'd0,
        paper_base:    8'd16,
        border_base:   8'd16
    };

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  scan_row;
        logic [9:0]  scan_col;
        logic        blink_phase;
        logic [12:0] write_address;
        logic [7:0]  write_data;
    } t_in;

    typedef struct packed {
        logic [7:0] pal_index;
        logic       in_content;
        logic [7:0] floating_attribute;
    } t_out;

    typedef enum logic [1:0] {
        OP_DISP_WR,
        OP_ATTR_WR,
        OP_PIXEL,
        OP_BORDER
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DISP_AW-1:0] disp_addr;
        logic [ATTR_AW-1:0] attr_addr;
        logic [2:0]         bit_pos;
        logic               phase;
        logic               content;
        logic [7:0]         data;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/asp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attribute screen pixel queue
// Small first-in first-out queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
module asp_fifo #(
    parameter type         t_data = logic [7:0],
    parameter int unsigned DEPTH  = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire t_data                      i_wdata,
    input  wire logic                       i_pop,
    output t_data                           o_rdata,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

### rtl/asp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attribute screen pixel front end
// Classify each item: store write, visible pixel, border, or dropped.
// ----------------------------------------------------------------------------
module asp_front (
    input  wire asp_pkg::t_in   i_item,
    input  wire asp_pkg::t_cfg  i_cfg,
    output asp_pkg::t_cmd       o_cmd,
    output logic                o_keep
);
    import asp_pkg::*;

    logic       row_in, col_in, content, visible;
    logic [8:0] row_off;
    logic [9:0] col_off;
    logic [7:0] row;
    logic [8:0] col;

    assign row_in  = (i_item.scan_row >= 9'(CONTENT_TOP))
                  && (i_item.scan_row < 9'(CONTENT_BOTTOM_END));
    assign col_in  = (i_item.scan_col >= 10'(CONTENT_LEFT))
                  && (i_item.scan_col < 10'(CONTENT_RIGHT_END));
    assign content = row_in && col_in;

    assign row_off = i_item.scan_row - 9'(CONTENT_TOP);
    assign col_off = i_item.scan_col - 10'(CONTENT_LEFT);
    assign row     = row_off[7:0];
    assign col     = col_off[8:0];

    assign visible = (row >= i_cfg.clip_top) && (row <= i_cfg.clip_bottom)
                  && (col >= i_cfg.clip_left) && (col <= i_cfg.clip_right);

    always_comb begin
        o_cmd.op        = OP_BORDER;
        o_cmd.disp_addr = {row[7:6], row[2:0], row[5:3], col[8:4]};
        o_cmd.attr_addr = {row[7:3], col[8:4]};
        o_cmd.bit_pos   = col[3:1];
        o_cmd.phase     = i_item.blink_phase;
        o_cmd.content   = content;
        o_cmd.data      = i_item.write_data;
        o_keep          = 1'b0;
        unique case (i_item.func)
            FUNC_BEAM: begin
                o_cmd.op = (content && visible) ? OP_PIXEL : OP_BORDER;
                o_keep   = 1'b1;
            end
            FUNC_DISP_WR: begin
                o_cmd.op        = OP_DISP_WR;
                o_cmd.disp_addr = i_item.write_address[DISP_AW-1:0];
                o_keep          = (i_item.write_address < 13'(DISPLAY_DEPTH));
            end
            FUNC_ATTR_WR: begin
                o_cmd.op        = OP_ATTR_WR;
                o_cmd.attr_addr = i_item.write_address[ATTR_AW-1:0];
                o_keep          = (i_item.write_address < 13'(ATTRIBUTE_DEPTH));
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/asp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attribute screen pixel back end
// Own the display and attribute stores, fetch, and pick the palette index.
// ----------------------------------------------------------------------------
module asp_back #(
    parameter int unsigned OUT_DEPTH = asp_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire asp_pkg::t_cfg                  i_cfg,
    input  wire asp_pkg::t_cmd                  i_cmd,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output asp_pkg::t_out                       o_res,
    output logic                                o_res_valid
);
    import asp_pkg::*;

    localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

    logic [7:0] disp_mem [DISPLAY_DEPTH];
    logic [7:0] attr_mem [ATTRIBUTE_DEPTH];

    logic [CW:0] used;
    logic        issue;
    logic        s1_load;

    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic [7:0]  r_disp_q;
    logic [7:0]  r_attr_q;
    logic [7:0]  r_last_attr, n_last_attr;

    logic [7:0]  ink, paper, colour, picked, border;
    logic        swap, lit;

    assign used    = {1'b0, i_out_count} + (CW + 1)'(r_s1_valid);
    assign issue   = i_cmd_valid && (used < (CW + 1)'(OUT_DEPTH));
    assign s1_load = issue && ((i_cmd.op == OP_PIXEL) || (i_cmd.op == OP_BORDER));
    assign o_cmd_pop = issue;

    always_ff @(posedge i_clk) begin
        if (issue && (i_cmd.op == OP_DISP_WR)) begin
            disp_mem[i_cmd.disp_addr] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && (i_cmd.op == OP_PIXEL)) begin
            r_disp_q <= disp_mem[i_cmd.disp_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && (i_cmd.op == OP_ATTR_WR)) begin
            attr_mem[i_cmd.attr_addr] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && (i_cmd.op == OP_PIXEL)) begin
            r_attr_q <= attr_mem[i_cmd.attr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_cmd <= i_cmd;
        end
    end

    always_comb begin
        ink    = i_cfg.ink_base + (r_attr_q & ATTR_INK_MASK);
        paper  = i_cfg.paper_base + ((r_attr_q >> 3) & ATTR_INK_MASK);
        swap   = ((r_attr_q & ATTR_FLASH) != '0) && r_s1_cmd.phase;
        lit    = r_disp_q[~r_s1_cmd.bit_pos];
        picked = (lit != swap) ? ink : paper;
        if ((r_attr_q & ATTR_BRIGHT) != '0) begin
            picked = picked + BRIGHT_STEP;
        end
        border = i_cfg.border_base + 8'(i_cfg.border_color);
        colour = border;
        n_last_attr = r_last_attr;
        case (r_s1_cmd.op)
            OP_PIXEL: begin
                colour      = picked;
                n_last_attr = r_attr_q;
            end
            default: begin
                colour = border;
            end
        endcase
        if (!r_s1_valid) begin
            n_last_attr = r_last_attr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_last_attr <= '0;
        end else begin
            r_s1_valid  <= s1_load;
            r_last_attr <= n_last_attr;
        end
    end

    assign o_res.pal_index          = colour;
    assign o_res.in_content         = r_s1_cmd.content;
    assign o_res.floating_attribute = n_last_attr;
    assign o_res_valid              = r_s1_valid;

endmodule
`default_nettype wire

### rtl/attribute_screen_pixel_generator_top.sv
`default_nettype none
// Beam positions pass the command queue, back end stage register and result queue.
// Throughput: one item per cycle unless full; the back end issues one queued
// item per cycle, bounded by the single read port of each store and the result
// queue space. Store writes and dropped items produce no result.
// Reset: synchronous, active low; registers take their defaults, queues empty,
// latched attribute clears; store contents stay undefined until written.
// ----------------------------------------------------------------------------
// Attribute screen pixel generator top level
// Configuration registers, front classifier, command queue, back end, results.
// ----------------------------------------------------------------------------
module attribute_screen_pixel_generator_top #(
    parameter int unsigned MID_DEPTH = asp_pkg::MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = asp_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire asp_pkg::t_in                  i_item,
    output logic                               empty,
    input  wire logic                          pop,
    output asp_pkg::t_out                      o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [asp_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire logic [asp_pkg::CFG_DW-1:0]    i_cfg_data
);
    import asp_pkg::*;

    t_cfg  r_cfg, n_cfg;
    t_cmd  front_cmd, mid_cmd;
    logic  front_keep;
    logic  mid_push, mid_pop, mid_full, mid_empty;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    t_out  back_res;
    logic  back_valid, out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BORDER_COLOR:  n_cfg.border_color  = i_cfg_data[2:0];
                CFG_CLIP_LEFT:     n_cfg.clip_left     = i_cfg_data[8:0];
                CFG_CLIP_RIGHT:    n_cfg.clip_right    = i_cfg_data[8:0];
                CFG_CLIP_TOP:      n_cfg.clip_top      = i_cfg_data[7:0];
                CFG_CLIP_BOTTOM:   n_cfg.clip_bottom   = i_cfg_data[7:0];
                CFG_INK_BASE:      n_cfg.ink_base      = i_cfg_data[7:0];
                CFG_PAPER_BASE:    n_cfg.paper_base    = i_cfg_data[7:0];
                CFG_BORDER_BASE:   n_cfg.border_base   = i_cfg_data[7:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    asp_front u_front (
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_cmd  (front_cmd),
        .o_keep (front_keep)
    );

    assign full     = mid_full;
    assign mid_push = push && !mid_full && front_keep;

    asp_fifo #(
        .t_data (t_cmd),
        .DEPTH  (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (front_cmd),
        .i_pop   (mid_pop),
        .o_rdata (mid_cmd),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    asp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (mid_cmd),
        .i_cmd_valid (!mid_empty),
        .o_cmd_pop   (mid_pop),
        .i_out_count (out_count),
        .o_res       (back_res),
        .o_res_valid (back_valid)
    );

    asp_fifo #(
        .t_data (t_out),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_valid),
        .i_wdata (back_res),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

`ifndef SYNTH
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(back_valid && out_full))
        else $error("result transfer into a full result queue");

    a_mid_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
        else $error("command queue count out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_border_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.in_content) |->
        (o_result.pal_index == 8'(r_cfg.border_base + 8'(r_cfg.border_color))))
        else $error("outside content window but not the border index");
`endif

endmodule
`default_nettype wire

### dv/tb_attribute_screen_pixel_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attribute screen pixel generator testbench
// Loads each store entry ahead of the first beam position that reads it, and
// runs directed and random store writes and beam positions under several
// register settings and handshake idling patterns. A scoreboard predicts
// every palette index and checks each result transfer against it in order.
// ----------------------------------------------------------------------------
module tb_attribute_screen_pixel_generator_top;

    import asp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         NUM_PHASES   = 6;
    localparam int         PHASE_ITEMS  = 275;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 400000;

    class screen_scoreboard;
        t_cfg       regs;
        logic [7:0] disp_mem [DISPLAY_DEPTH];
        logic [7:0] attr_mem [ATTRIBUTE_DEPTH];
        logic [7:0] latched_attr;
        t_out       expected_pixels [$];
        int         errors;

        function new();
            regs         = CFG_RESET;
            latched_attr = '0;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [8:0] v);
            case (idx)
                CFG_BORDER_COLOR:  regs.border_color  = v[2:0];
                CFG_CLIP_LEFT:     regs.clip_left     = v;
                CFG_CLIP_RIGHT:    regs.clip_right    = v;
                CFG_CLIP_TOP:      regs.clip_top      = v[7:0];
                CFG_CLIP_BOTTOM:   regs.clip_bottom   = v[7:0];
                CFG_INK_BASE:      regs.ink_base      = v[7:0];
                CFG_PAPER_BASE:    regs.paper_base    = v[7:0];
                CFG_BORDER_BASE:   regs.border_base   = v[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_item(t_in it);
            logic [7:0]  r;
            logic [8:0]  c;
            logic [7:0]  px;
            logic [4:0]  tile;
            logic [9:0]  attr_addr;
            logic [12:0] disp_addr;
            logic [7:0]  attr;
            logic [7:0]  disp;
            logic [7:0]  ink;
            logic [7:0]  paper;
            logic [7:0]  colour;
            logic        swap;
            logic        lit;
            logic        content;
            t_out        exp_pix;
            case (it.func)
                FUNC_DISP_WR: begin
                    if (it.write_address < DISPLAY_DEPTH)
                        disp_mem[it.write_address] = it.write_data;
                end
                FUNC_ATTR_WR: begin
                    if (it.write_address < ATTRIBUTE_DEPTH)
                        attr_mem[it.write_address] = it.write_data;
                end
                FUNC_BEAM: begin
                    colour  = regs.border_base + 8'(regs.border_color);
                    content = it.scan_row >= CONTENT_TOP && it.scan_row < CONTENT_BOTTOM_END &&
                              it.scan_col >= CONTENT_LEFT &&
                              it.scan_col < CONTENT_RIGHT_END;
                    if (content) begin
                        r = 8'(it.scan_row - CONTENT_TOP);
                        c = 9'(it.scan_col - CONTENT_LEFT);
                        if (r >= regs.clip_top && r <= regs.clip_bottom &&
                            c >= regs.clip_left && c <= regs.clip_right) begin
                            px        = c[8:1];
                            tile      = px[7:3];
                            attr_addr = 10'(r[7:3]) * 10'd32 + 10'(tile);
                            disp_addr = {r[7:6], r[2:0], r[5:3], tile};
                            attr      = attr_mem[attr_addr];
                            disp      = disp_mem[disp_addr];
                            ink       = regs.ink_base + (attr & ATTR_INK_MASK);
                            paper     = regs.paper_base + 8'(attr[5:3]);
                            swap      = ((attr & ATTR_FLASH) != 0) && it.blink_phase;
                            lit       = disp[3'd7 - px[2:0]];
                            if (lit)
                                colour = swap ? paper : ink;
                            else
                                colour = swap ? ink : paper;
                            if ((attr & ATTR_BRIGHT) != 0)
                                colour = colour + BRIGHT_STEP;
                            latched_attr = attr;
                        end
                    end
                    exp_pix.pal_index          = colour;
                    exp_pix.in_content         = content;
                    exp_pix.floating_attribute = latched_attr;
                    expected_pixels.push_back(exp_pix);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(t_out got);
            t_out exp_pix;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            exp_pix = expected_pixels.pop_front();
            if (got.pal_index !== exp_pix.pal_index) begin
                $display("%0t: pal_index expected %0d got %0d", $time,
                         exp_pix.pal_index, got.pal_index);
                errors++;
            end
            if (got.in_content !== exp_pix.in_content) begin
                $display("%0t: in_content expected %0d got %0d", $time,
                         exp_pix.in_content, got.in_content);
                errors++;
            end
            if (got.floating_attribute !== exp_pix.floating_attribute) begin
                $display("%0t: floating_attribute expected %h got %h", $time,
                         exp_pix.floating_attribute, got.floating_attribute);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    t_in        i_item      = '0;
    logic       empty;
    logic       pop         = 1'b0;
    t_out       o_result;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [8:0] i_cfg_data  = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles      = 0;
    int sent        = 0;

    bit disp_loaded [DISPLAY_DEPTH];
    bit attr_loaded [ATTRIBUTE_DEPTH];

    screen_scoreboard sb = new();

    attribute_screen_pixel_generator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_pixel(o_result);
            if (push && !full)
                sb.note_item(i_item);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_in noise_item();
        t_in it;
        it.func          = 2'($urandom_range(0, 3));
        it.scan_row      = 9'($urandom_range(0, 511));
        it.scan_col      = 10'($urandom_range(0, 1023));
        it.blink_phase   = 1'($urandom_range(0, 1));
        it.write_address = 13'($urandom_range(0, 8191));
        it.write_data    = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_in beam_at(int row, int col, bit ph);
        t_in it;
        it             = noise_item();
        it.func        = FUNC_BEAM;
        it.scan_row    = 9'(row);
        it.scan_col    = 10'(col);
        it.blink_phase = ph;
        return it;
    endfunction

    function automatic t_in store_write(logic [1:0] f, int addr, logic [7:0] d);
        t_in it;
        it               = noise_item();
        it.func          = f;
        it.write_address = 13'(addr);
        it.write_data    = d;
        return it;
    endfunction

    function automatic bit pixel_fetch(t_in it, t_cfg c, output logic [12:0] d_addr,
                                       output logic [9:0] a_addr);
        logic [7:0] r;
        logic [8:0] col;
        d_addr = '0;
        a_addr = '0;
        if (it.func != FUNC_BEAM || it.scan_row < CONTENT_TOP ||
            it.scan_row >= CONTENT_BOTTOM_END || it.scan_col < CONTENT_LEFT ||
            it.scan_col >= CONTENT_RIGHT_END)
            return 1'b0;
        r      = 8'(it.scan_row - CONTENT_TOP);
        col    = 9'(it.scan_col - CONTENT_LEFT);
        d_addr = {r[7:6], r[2:0], r[5:3], col[8:4]};
        a_addr = {r[7:3], col[8:4]};
        return r >= c.clip_top && r <= c.clip_bottom &&
               col >= c.clip_left && col <= c.clip_right;
    endfunction

    function automatic t_in rand_item(t_cfg c);
        t_in it;
        int  k;
        int  rows [4] = '{31, 32, 223, 224};
        int  cols [4] = '{63, 64, 575, 576};
        it = noise_item();
        k  = $urandom_range(0, 99);
        if (k < 35 && c.clip_left <= c.clip_right && c.clip_top <= c.clip_bottom) begin
            it = beam_at(CONTENT_TOP + $urandom_range(c.clip_top, c.clip_bottom),
                         CONTENT_LEFT + $urandom_range(c.clip_left, c.clip_right),
                         $urandom_range(0, 1));
        end else if (k < 60) begin
            it = beam_at(CONTENT_TOP + $urandom_range(0, 191),
                         CONTENT_LEFT + $urandom_range(0, 511), $urandom_range(0, 1));
        end else if (k < 70) begin
            it.func = FUNC_BEAM;
        end else if (k < 82) begin
            it.func = FUNC_DISP_WR;
            if ($urandom_range(0, 7) != 0)
                it.write_address = 13'($urandom_range(0, DISPLAY_DEPTH - 1));
        end else if (k < 95) begin
            it.func = FUNC_ATTR_WR;
            if ($urandom_range(0, 7) != 0)
                it.write_address = 13'($urandom_range(0, ATTRIBUTE_DEPTH - 1));
            else
                it.write_address = 13'($urandom_range(ATTRIBUTE_DEPTH, 8191));
        end else if (k < 97) begin
            it.func = FUNC_UNUSED;
        end else begin
            it = beam_at(rows[$urandom_range(0, 3)], cols[$urandom_range(0, 3)],
                         $urandom_range(0, 1));
        end
        return it;
    endfunction

    task automatic drive_item(t_in it);
        if (it.func == FUNC_DISP_WR && it.write_address < DISPLAY_DEPTH)
            disp_loaded[it.write_address] = 1'b1;
        if (it.func == FUNC_ATTR_WR && it.write_address < ATTRIBUTE_DEPTH)
            attr_loaded[it.write_address] = 1'b1;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sent++;
    endtask

    task automatic send_item(t_in it);
        logic [12:0] d_addr;
        logic [9:0]  a_addr;
        // load the entries a visible beam position reads before it goes out
        if (pixel_fetch(it, sb.regs, d_addr, a_addr)) begin
            if (!disp_loaded[d_addr])
                drive_item(store_write(FUNC_DISP_WR, int'(d_addr),
                                       8'($urandom_range(0, 255))));
            if (!attr_loaded[a_addr])
                drive_item(store_write(FUNC_ATTR_WR, int'(a_addr),
                                       8'($urandom_range(0, 255))));
        end
        drive_item(it);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        t_cfg_idx   idx;
        logic [8:0] v;
        for (int k = 0; k < 8; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_BORDER_COLOR:  v = 9'(c.border_color);
                CFG_CLIP_LEFT:     v = c.clip_left;
                CFG_CLIP_RIGHT:    v = c.clip_right;
                CFG_CLIP_TOP:      v = 9'(c.clip_top);
                CFG_CLIP_BOTTOM:   v = 9'(c.clip_bottom);
                CFG_INK_BASE:      v = 9'(c.ink_base);
                CFG_PAPER_BASE:    v = 9'(c.paper_base);
                default:           v = 9'(c.border_base);
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= v;
            @(posedge i_clk);
            sb.set_reg(idx, v);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_cfg next_cfg;
        t_in  it;
        int   start;
        bit   drained;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 2) begin
                tx_idle_pct = 16;
                rx_idle_pct = 88;
            end else if (p < 4) begin
                tx_idle_pct = 88;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 0) begin
                send_item(beam_at(32, 64, 0));
                send_item(beam_at(32, 575, 1));
                send_item(beam_at(223, 64, 0));
                send_item(beam_at(223, 575, 1));
                send_item(beam_at(31, 64, 0));
                send_item(beam_at(224, 575, 0));
                send_item(beam_at(32, 63, 0));
                send_item(beam_at(32, 576, 1));
                send_item(beam_at(511, 1023, 1));
                send_item(beam_at(0, 0, 0));
                send_item(store_write(FUNC_ATTR_WR, 0, 8'hFF));
                send_item(store_write(FUNC_DISP_WR, 0, 8'hA5));
                send_item(beam_at(32, 64, 1));
                send_item(beam_at(32, 66, 1));
                send_item(beam_at(32, 64, 0));
                send_item(store_write(FUNC_ATTR_WR, 0, ATTR_FLASH | 8'h0A));
                send_item(beam_at(32, 64, 1));
                send_item(beam_at(32, 66, 0));
                send_item(store_write(FUNC_DISP_WR, DISPLAY_DEPTH, 8'h00));
                send_item(store_write(FUNC_DISP_WR, 8191, 8'hFF));
                send_item(store_write(FUNC_ATTR_WR, ATTRIBUTE_DEPTH, 8'hFF));
                send_item(store_write(FUNC_ATTR_WR, 8191, 8'h00));
                it      = noise_item();
                it.func = FUNC_UNUSED;
                send_item(it);
                send_item(beam_at(32, 64, 1));
            end else begin
                next_cfg.border_color  = 3'($urandom_range(0, 7));
                next_cfg.ink_base      = 8'($urandom_range(0, 255));
                next_cfg.paper_base    = 8'($urandom_range(0, 255));
                next_cfg.border_base   = 8'($urandom_range(0, 255));
                next_cfg.clip_left     = 9'($urandom_range(0, 511));
                next_cfg.clip_right    = 9'($urandom_range(0, 511));
                next_cfg.clip_top      = 8'($urandom_range(0, 191));
                next_cfg.clip_bottom   = 8'($urandom_range(0, 191));
                case (p)
                    1: next_cfg = '{border_color: 3'd7, clip_left: 9'd0, clip_right: 9'd511,
                                    clip_top: 8'd0, clip_bottom: 8'd191, ink_base: 8'd255,
                                    paper_base: 8'd255, border_base: 8'd255};
                    2: next_cfg = '{border_color: 3'd0, clip_left: 9'd511, clip_right: 9'd0,
                                    clip_top: 8'd191, clip_bottom: 8'd0, ink_base: 8'd0,
                                    paper_base: 8'd0, border_base: 8'd0};
                    3: begin
                        next_cfg.clip_right  = 9'($urandom_range(next_cfg.clip_left, 511));
                        next_cfg.clip_bottom = 8'($urandom_range(next_cfg.clip_top, 191));
                    end
                    5: begin
                        next_cfg.clip_left   = 9'($urandom_range(0, 500));
                        next_cfg.clip_right  = next_cfg.clip_left + 9'($urandom_range(0, 11));
                        next_cfg.clip_bottom = next_cfg.clip_top;
                    end
                    default: ;
                endcase
                drain_results();
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                apply_cfg(next_cfg);
            end
            start   = sent;
            drained = 1'b0;
            while (sent - start < PHASE_ITEMS) begin
                if (!drained && sent - start >= PHASE_ITEMS / 2) begin
                    drain_results();
                    drained = 1'b1;
                end
                send_item(rand_item(sb.regs));
            end
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/asp_pkg.sv
rtl/asp_fifo.sv
rtl/asp_front.sv
rtl/asp_back.sv
rtl/attribute_screen_pixel_generator_top.sv
dv/tb_attribute_screen_pixel_generator_top.sv
